FILE: design/oets_pkg.sv
// Shared types and constants for the odd-even transposition sorter.
package oets_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_e;

  // Per-cell operation for the current cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_CMP_LEFT,
    OP_CMP_RIGHT,
    OP_SHIFT
  } cell_op_e;

endpackage

FILE: design/oets_cell.sv
// One element cell of the sorting row: load, compare-exchange, shift.
module oets_cell (
  input  logic              clk_i,
  input  oets_pkg::cell_op_e op_i,
  input  oets_pkg::data_t   load_value_i,
  input  oets_pkg::data_t   left_value_i,
  input  oets_pkg::data_t   right_value_i,
  output oets_pkg::data_t   value_o
);

  oets_pkg::data_t value_d, value_q;

  always_comb begin
    value_d = value_q;
    case (op_i)
      oets_pkg::OP_HOLD: value_d = value_q;
      oets_pkg::OP_LOAD: value_d = load_value_i;
      // left of a pair keeps the smaller
      oets_pkg::OP_CMP_LEFT: begin
        if (value_q > right_value_i) value_d = right_value_i;
      end
      // right of a pair keeps the larger
      oets_pkg::OP_CMP_RIGHT: begin
        if (left_value_i > value_q) value_d = left_value_i;
      end
      oets_pkg::OP_SHIFT: value_d = right_value_i;
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: design/odd_even_transposition_sort_unit.sv
// Top level of the odd-even transposition sorter: sequencer and cell row.
//
// Input channel (in_valid_i / in_ready_o): one signed 32-bit value per
// transfer, last_i marks the final element of a set. Elements are written
// into a row of MAX_ELEMENTS cells, one per cycle. Elements arriving with
// the row full are dropped and the set is flagged with overflow_o.
// After the last transfer the row runs n compare-exchange phases, one per
// cycle (n = stored elements), each cell swapping with its neighbor as the
// phase parity says. Results then leave cell 0 as the row shifts toward it,
// one per output transfer (out_valid_o / out_ready_i), ascending, with
// last_out_o on the final one.
// Each set passes through loading, sorting and draining in turn, and
// in_ready_o is low while sorting or draining, so a new set is taken
// only after the last result has left. A stalled receiver simply holds
// the row; cell 0 is the output register. Reset empties the set and
// returns to loading; cell contents are not cleared, only stored entries
// are ever read.
module odd_even_transposition_sort_unit #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [oets_pkg::DATA_W-1:0] value_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [oets_pkg::DATA_W-1:0] sorted_value_o,
  output logic                               last_out_o,
  output logic                               overflow_o
);

  // count holds 0..MAX_ELEMENTS
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  oets_pkg::state_e state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;   // stored elements / results left
  logic [CNT_W-1:0] phase_d, phase_q;
  logic             dropped_d, dropped_q;

  logic in_xfer, out_xfer, full, sort_done;

  oets_pkg::data_t  cell_value [MAX_ELEMENTS];
  oets_pkg::cell_op_e cell_op  [MAX_ELEMENTS];

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_xfer  = out_valid_o && out_ready_i;
  assign full      = (count_q == CNT_W'(MAX_ELEMENTS));
  assign sort_done = (phase_q == CNT_W'(count_q - 1'b1));

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    phase_d   = phase_q;
    dropped_d = dropped_q;
    case (state_q)
      oets_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (full) dropped_d = 1'b1;
          else      count_d   = count_q + 1'b1;
          if (last_i) begin
            state_d = oets_pkg::ST_SORT;
            phase_d = '0;
          end
        end
      end
      oets_pkg::ST_SORT: begin
        phase_d = phase_q + 1'b1;
        if (sort_done) state_d = oets_pkg::ST_DRAIN;
      end
      oets_pkg::ST_DRAIN: begin
        if (out_xfer) begin
          count_d = count_q - 1'b1;
          if (count_q == CNT_W'(1)) begin
            state_d   = oets_pkg::ST_LOAD;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = oets_pkg::ST_LOAD;
    endcase
  end

  // Output / handshake logic
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      oets_pkg::ST_LOAD:  in_ready_o  = 1'b1;
      oets_pkg::ST_SORT:  ;
      oets_pkg::ST_DRAIN: out_valid_o = 1'b1;
      default:            ;
    endcase
  end

  assign sorted_value_o = cell_value[0];
  assign last_out_o     = (count_q == CNT_W'(1));
  assign overflow_o     = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= oets_pkg::ST_LOAD;
      count_q   <= '0;
      phase_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      dropped_q <= dropped_d;
    end
  end

  // Cell row. Phase parity picks the pair alignment; a pair is active
  // only when its right member lies below the stored count.
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    logic is_left, is_right;
    oets_pkg::data_t left_v, right_v;

    assign is_left = (phase_q[0] == 1'(k % 2)) && (CNT_W'(k + 1) < count_q);
    if (k > 0) begin : g_r
      assign is_right = (phase_q[0] == 1'((k - 1) % 2)) && (CNT_W'(k) < count_q);
      assign left_v   = cell_value[k-1];
    end else begin : g_r0
      assign is_right = 1'b0;
      assign left_v   = cell_value[k];
    end
    if (k < MAX_ELEMENTS - 1) begin : g_n
      assign right_v = cell_value[k+1];
    end else begin : g_nl
      assign right_v = cell_value[k];
    end

    always_comb begin
      cell_op[k] = oets_pkg::OP_HOLD;
      case (state_q)
        oets_pkg::ST_LOAD: begin
          if (in_xfer && (count_q == CNT_W'(k))) cell_op[k] = oets_pkg::OP_LOAD;
        end
        oets_pkg::ST_SORT: begin
          if (is_left)       cell_op[k] = oets_pkg::OP_CMP_LEFT;
          else if (is_right) cell_op[k] = oets_pkg::OP_CMP_RIGHT;
        end
        oets_pkg::ST_DRAIN: begin
          if (out_xfer) cell_op[k] = oets_pkg::OP_SHIFT;
        end
        default: cell_op[k] = oets_pkg::OP_HOLD;
      endcase
    end

    oets_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (cell_op[k]),
      .load_value_i  (value_i),
      .left_value_i  (left_v),
      .right_value_i (right_v),
      .value_o       (cell_value[k])
    );
  end

  // Assertions
  a_no_empty_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0))
    else $error("results offered from an empty set");

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_i) |=> (state_q == oets_pkg::ST_SORT))
    else $error("last transfer did not start the sort");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oets_pkg::ST_SORT) |-> (phase_q < count_q))
    else $error("sort ran past n phases");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_out_o) |=> (out_valid_o && (count_q == $past(count_q) - 1'b1)))
    else $error("drain count slipped");

endmodule

FILE: tb/sv/oets_checker.sv
// Checker for the sorter: predicts each set's sorted results and compares them.
module oets_checker #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_o,
  input  oets_pkg::data_t value_i,
  input  logic            last_i,
  input  logic            out_valid_o,
  input  logic            out_ready_i,
  input  oets_pkg::data_t sorted_value_o,
  input  logic            last_out_o,
  input  logic            overflow_o,
  output int unsigned     pending_o,
  output int unsigned     mismatches_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef oets_pkg::data_t elem_q_t[$];

  typedef struct packed {
    oets_pkg::data_t value;
    logic            last;
    logic            overflow;
  } sorted_rec_t;

  elem_q_t     set_elems;      // elements held for the open set
  logic        set_dropped;    // an element of the open set was lost
  sorted_rec_t sorted_q[$];    // results still owed by the block
  elem_q_t     ordered;
  sorted_rec_t rec;
  sorted_rec_t want;
  int unsigned mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // Odd-even transposition, signed, ascending.
  function automatic elem_q_t sort_ascending(elem_q_t elems);
    oets_pkg::data_t held;
    int              n;
    n = elems.size();
    for (int p = 0; p < n; p++) begin
      for (int j = p % 2; j + 1 < n; j += 2) begin
        if (elems[j] > elems[j+1]) begin
          held       = elems[j];
          elems[j]   = elems[j+1];
          elems[j+1] = held;
        end
      end
    end
    return elems;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_elems.delete();
      set_dropped = 1'b0;
      sorted_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (set_elems.size() < MAX_ELEMENTS) begin
          set_elems = {set_elems, value_i};
        end else begin
          set_dropped = 1'b1;
        end
        if (last_i) begin
          ordered = sort_ascending(set_elems);
          foreach (ordered[k]) begin
            rec.value    = ordered[k];
            rec.last     = (k == ordered.size() - 1);
            rec.overflow = set_dropped;
            sorted_q     = {sorted_q, rec};
          end
          set_elems.delete();
          set_dropped = 1'b0;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d", sorted_value_o));
        end else begin
          want = sorted_q.pop_front();
          if (sorted_value_o !== want.value)
            report_mismatch($sformatf("sorted_value got %0d want %0d",
                                      sorted_value_o, want.value));
          if (last_out_o !== want.last)
            report_mismatch($sformatf("last_out got %b want %b (value %0d)",
                                      last_out_o, want.last, want.value));
          if (overflow_o !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b (value %0d)",
                                      overflow_o, want.overflow, want.value));
        end
      end
      pending_o <= sorted_q.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top for the sorter: clock, reset, stimulus, receiver and verdict.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ELEMENTS = 16;
  localparam int unsigned NUM_ITEMS    = 500;
  // Idle limit: covers the long receiver hold-off plus a full sort pass.
  localparam int unsigned IDLE_LIMIT   = 3000;
  // Receiver hold-off that lets the block fill and block its input.
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Drain margin after the last expected result.
  localparam int unsigned TAIL_CYCLES  = 2 * MAX_ELEMENTS + 8;

  localparam oets_pkg::data_t VAL_MAX = 32'sh7fff_ffff;
  localparam oets_pkg::data_t VAL_MIN = 32'sh8000_0000;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  oets_pkg::data_t value_i     = '0;
  logic            last_i      = 1'b0;
  logic            out_ready_i = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  oets_pkg::data_t sorted_value_o;
  logic            last_out_o;
  logic            overflow_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;

  // Sender pacing for the current set: burst means back-to-back transfers.
  logic burst = 1'b0;

  odd_even_transposition_sort_unit #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  oets_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: any cycle with neither an input nor an output transfer counts
  // toward the limit; a transfer on either side clears it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one element and hold it until the transfer. Called at a rising
  // edge; returns at the edge where the transfer happened, so a following
  // call with no gap keeps valid high without a drop.
  task automatic send_item(input oets_pkg::data_t v, input logic lst);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    value_i    <= v;
    last_i     <= lst;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: random stall before each result, with steady stretches and one
  // long hold-off while the sender keeps offering, so the input backs up.
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    logic        steady;
    taken  = 0;
    steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 32 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Stimulus: directed corner sets first, then random sets.
  initial begin : stimulus
    int unsigned     sent;
    int unsigned     set_len;
    int unsigned     mode;
    oets_pkg::data_t v;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-element sets at both extremes.
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    // Two elements, reversed extremes: one swap across the sign boundary.
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
    // Full store plus one: the closing element itself is dropped, so the
    // set still sorts the stored elements and flags overflow on each.
    burst = 1'b1;
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      v = (k % 2 == 0) ? VAL_MAX - k : VAL_MIN + k;
      send_item(v, k == MAX_ELEMENTS);
    end
    burst = 1'b0;
    // Duplicates and mixed signs.
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b1);

    // Random sets: mostly within capacity, sometimes overflowing.
    sent = 0;
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        set_len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 6);
      end else if ($urandom_range(0, 2) == 0) begin
        set_len = $urandom_range(1, 3);
      end else begin
        set_len = $urandom_range(1, MAX_ELEMENTS);
      end
      burst = ($urandom_range(0, 3) == 0);
      mode  = $urandom_range(0, 3);
      for (int k = 0; k < set_len; k++) begin
        case (mode)
          0, 1: v = $urandom;
          // narrow range: many ties
          2: v = $signed($urandom_range(0, 16)) - 32'sd8;
          default: begin
            case ($urandom_range(0, 5))
              0: v = VAL_MIN;
              1: v = VAL_MAX;
              2: v = VAL_MIN + 1;
              3: v = VAL_MAX - 1;
              4: v = -32'sd1;
              default: v = '0;
            endcase
          end
        endcase
        send_item(v, k == set_len - 1);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Let the checker see the final transfer, then drain.
    @(posedge clk_i);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/oets_pkg.sv
design/oets_cell.sv
design/odd_even_transposition_sort_unit.sv
tb/sv/oets_checker.sv
tb/sv/testbench.sv
